@@ sv/ita_pkg.sv @@
// ---------------------------------------------------------------------------
// ita_pkg
// Shared types, format codes and character helpers for the integer to ASCII
// formatter.
// ---------------------------------------------------------------------------
package ita_pkg;

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEXL = 3'd2;
    localparam logic [2:0] OP_HEXU = 3'd3;
    localparam logic [2:0] OP_PTR  = 3'd4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int NDIGITS     = 16;
    localparam int DIDX_W      = $clog2(NDIGITS);

    // Reciprocal of ten, scaled by 2^35: exact quotient for every 32-bit value
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_X     = 8'h78;
    localparam logic [7:0] CHR_LOWA  = 8'h61;
    localparam logic [7:0] CHR_UPA   = 8'h41;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX
    } pfx_t;

    typedef struct packed {
        logic [63:0] mag;
        logic        dec;
        logic        upper;
        pfx_t        pfx;
    } desc_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_PFX,
        BK_DIGIT
    } bk_state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10)
            begin
                c = CHR_ZERO + {4'd0, d};
            end
            else if (upper)
            begin
                c = CHR_UPA + {4'd0, d} - 8'd10;
            end
            else
            begin
                c = CHR_LOWA + {4'd0, d} - 8'd10;
            end
            return c;
        end
    endfunction

endpackage

@@ sv/ita_front.sv @@
// ---------------------------------------------------------------------------
// ita_front
// Input stage: registers one item, sorts it by format, works out the
// magnitude and prefix, and passes a descriptor on to the queue (unknown formats are dropped).
// ---------------------------------------------------------------------------
module ita_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         op,
    input  logic [63:0]        value,
    output logic               q_push,
    input  logic               q_full,
    output ita_pkg::desc_t     q_data
);

    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic [2:0]  op_reg;
    logic [63:0] value_reg;
    logic        known;
    logic        leave;
    logic        accept;
    logic [31:0] lo;

    assign lo = value_reg[31:0];

    always_comb
    begin
        known        = 1'b1;
        q_data.mag   = {32'd0, lo};
        q_data.dec   = 1'b0;
        q_data.upper = 1'b0;
        q_data.pfx   = ita_pkg::PFX_NONE;
        case (op_reg)
            ita_pkg::OP_SDEC:
            begin
                q_data.dec = 1'b1;
                if (lo[31])
                begin
                    q_data.mag = {32'd0, ~lo + 32'd1};
                    q_data.pfx = ita_pkg::PFX_MINUS;
                end
            end
            ita_pkg::OP_UDEC:
            begin
                q_data.dec = 1'b1;
            end
            ita_pkg::OP_HEXL:
            begin
                q_data.upper = 1'b0;
            end
            ita_pkg::OP_HEXU:
            begin
                q_data.upper = 1'b1;
            end
            ita_pkg::OP_PTR:
            begin
                q_data.mag = value_reg;
                q_data.pfx = ita_pkg::PFX_HEX;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // drop unknown formats without touching the queue
    assign leave           = hold_valid_reg && (!known || !q_full);
    assign q_push          = hold_valid_reg && known && !q_full;
    assign full            = hold_valid_reg && !leave;
    assign accept          = push && !full;
    assign hold_valid_next = accept ? 1'b1 : (leave ? 1'b0 : hold_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
    end

endmodule

@@ sv/ita_queue.sv @@
// ---------------------------------------------------------------------------
// ita_queue
// Short descriptor queue between the front and back stages.
// ---------------------------------------------------------------------------
module ita_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    output logic               q_full,
    input  ita_pkg::desc_t     wr_data,
    output logic               rd_valid,
    input  logic               rd_en,
    output ita_pkg::desc_t     rd_data
);

    ita_pkg::desc_t                data_reg [ita_pkg::QUEUE_DEPTH];
    logic [ita_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [ita_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [ita_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [ita_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [ita_pkg::QPTR_W:0]      count_reg;
    logic [ita_pkg::QPTR_W:0]      count_next;
    logic                          do_wr;
    logic                          do_rd;

    assign q_full   = (count_reg == (ita_pkg::QPTR_W+1)'(ita_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = data_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == ita_pkg::QPTR_W'(ita_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == ita_pkg::QPTR_W'(ita_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + {{ita_pkg::QPTR_W{1'b0}}, do_wr}
                               - {{ita_pkg::QPTR_W{1'b0}}, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ sv/ita_back.sv @@
// ---------------------------------------------------------------------------
// ita_back
// Conversion stage: peels one digit a cycle into a buffer, then emits the
// prefix and the digits, most significant first, through an output register.
// ---------------------------------------------------------------------------
module ita_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_valid,
    output logic               rd_en,
    input  ita_pkg::desc_t     rd_data,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         character,
    output logic               last
);

    ita_pkg::bk_state_t          state_reg;
    ita_pkg::bk_state_t          state_next;
    logic [63:0]                 mag_reg;
    logic [63:0]                 mag_next;
    logic                        dec_reg;
    logic                        upper_reg;
    ita_pkg::pfx_t               pfx_reg;
    logic                        sub_reg;
    logic                        sub_next;
    logic [ita_pkg::DIDX_W:0]    cnt_reg;
    logic [ita_pkg::DIDX_W:0]    cnt_next;
    logic [3:0]                  buf_reg [ita_pkg::NDIGITS];
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [7:0]                  char_reg;
    logic                        last_reg;

    logic [63:0]                 prod;
    logic [31:0]                 quot;
    logic [31:0]                 diff;
    logic [3:0]                  digit;
    logic [63:0]                 mag_step;
    logic                        emit_ok;
    logic                        emit;
    logic [7:0]                  emit_char;
    logic                        emit_last;
    logic                        store;
    logic [ita_pkg::DIDX_W:0]    cnt_dec;
    logic [3:0]                  rd_digit;

    assign prod     = {32'd0, mag_reg[31:0]} * {32'd0, ita_pkg::RECIP10};
    assign quot     = 32'(prod[63:ita_pkg::RECIP10_SHIFT]);
    assign diff     = mag_reg[31:0] - ((quot << 3) + (quot << 1));
    assign digit    = dec_reg ? diff[3:0] : mag_reg[3:0];
    assign mag_step = dec_reg ? {32'd0, quot} : {4'd0, mag_reg[63:4]};
    assign cnt_dec  = cnt_reg - 1'b1;
    assign rd_digit = buf_reg[cnt_dec[ita_pkg::DIDX_W-1:0]];
    assign emit_ok  = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ita_pkg::BK_IDLE:
            begin
                if (rd_valid)
                begin
                    state_next = ita_pkg::BK_CONV;
                end
            end
            ita_pkg::BK_CONV:
            begin
                if (mag_step == '0)
                begin
                    state_next = (pfx_reg == ita_pkg::PFX_NONE) ? ita_pkg::BK_DIGIT
                                                                : ita_pkg::BK_PFX;
                end
            end
            ita_pkg::BK_PFX:
            begin
                if (emit_ok && (pfx_reg == ita_pkg::PFX_MINUS || sub_reg))
                begin
                    state_next = ita_pkg::BK_DIGIT;
                end
            end
            ita_pkg::BK_DIGIT:
            begin
                if (emit_ok && cnt_reg == (ita_pkg::DIDX_W+1)'(1))
                begin
                    state_next = ita_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ita_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en     = 1'b0;
        store     = 1'b0;
        emit      = 1'b0;
        emit_char = ita_pkg::CHR_ZERO;
        emit_last = 1'b0;
        mag_next  = mag_reg;
        cnt_next  = cnt_reg;
        sub_next  = sub_reg;
        case (state_reg)
            ita_pkg::BK_IDLE:
            begin
                rd_en    = rd_valid;
                mag_next = rd_data.mag;
                cnt_next = '0;
                sub_next = 1'b0;
            end
            ita_pkg::BK_CONV:
            begin
                store    = 1'b1;
                mag_next = mag_step;
                cnt_next = cnt_reg + 1'b1;
            end
            ita_pkg::BK_PFX:
            begin
                emit = emit_ok;
                if (pfx_reg == ita_pkg::PFX_MINUS)
                begin
                    emit_char = ita_pkg::CHR_MINUS;
                end
                else if (sub_reg)
                begin
                    emit_char = ita_pkg::CHR_X;
                end
                if (emit_ok)
                begin
                    sub_next = 1'b1;
                end
            end
            ita_pkg::BK_DIGIT:
            begin
                emit      = emit_ok;
                emit_char = ita_pkg::digit_char(rd_digit, upper_reg);
                emit_last = (cnt_reg == (ita_pkg::DIDX_W+1)'(1));
                if (emit_ok)
                begin
                    cnt_next = cnt_dec;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
        out_valid_next = emit ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ita_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        cnt_reg <= cnt_next;
        sub_reg <= sub_next;
        if (rd_en)
        begin
            dec_reg   <= rd_data.dec;
            upper_reg <= rd_data.upper;
            pfx_reg   <= rd_data.pfx;
        end
        if (store)
        begin
            buf_reg[cnt_reg[ita_pkg::DIDX_W-1:0]] <= digit;
        end
        if (emit)
        begin
            char_reg <= emit_char;
            last_reg <= emit_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

@@ sv/integer_to_ascii_formatter.sv @@
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter
// Turns a number into its ASCII characters in signed or unsigned decimal,
// hex in either case, or 0x-prefixed 64-bit pointer form.
// ---------------------------------------------------------------------------
// Conversion: the back stage peels one digit a cycle into a buffer, then emits
//   one character a cycle while the receiver keeps popping; at most 18 characters
//   per item (a 16-digit pointer). It takes a new item from the queue only once
//   the last character of the item before is emitted; front and queue hold the rest.
// Reset: asynchronous, clears all control state; no clearing pass.
module integer_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  op,
    input  logic [63:0] value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  character,
    output logic        last
);

    logic              q_push;
    logic              q_full;
    ita_pkg::desc_t    q_wdata;
    logic              q_rvalid;
    logic              q_rd;
    ita_pkg::desc_t    q_rdata;

    ita_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .op     (op),
        .value  (value),
        .q_push (q_push),
        .q_full (q_full),
        .q_data (q_wdata)
    );

    ita_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .q_full   (q_full),
        .wr_data  (q_wdata),
        .rd_valid (q_rvalid),
        .rd_en    (q_rd),
        .rd_data  (q_rdata)
    );

    ita_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_valid  (q_rvalid),
        .rd_en     (q_rd),
        .rd_data   (q_rdata),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last      (last)
    );

endmodule

@@ tb/integer_to_ascii_formatter_tb.sv @@
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Self-checking bench for the integer to ASCII formatter. Directed words cover
// the edges of each format; random words follow, with random gaps on both
// sides and long receiver hold-offs that back the block up. Every character
// popped is compared with the text predicted for the words pushed.
// ---------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    localparam int RANDOM_WORDS   = 305;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 48;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } glyph_t;

    class char_ledger;
        glyph_t pending[$];
        int     mismatches;
        int     chars_seen;

        function new();
            mismatches = 0;
            chars_seen = 0;
        endfunction

        function void note_word(input logic [2:0] fmt, input logic [63:0] val);
            logic [63:0] mag;
            logic [63:0] radix;
            logic        upper;
            logic [3:0]  digs [16];
            logic [7:0]  c;
            int          nd;
            begin
                mag   = val;
                radix = 64'd16;
                upper = 1'b0;
                case (fmt)
                    ita_pkg::OP_SDEC:
                    begin
                        radix = 64'd10;
                        mag   = {32'd0, val[31:0]};
                        if (val[31])
                        begin
                            pending.push_back('{ch: 8'h2D, last: 1'b0});
                            mag = {32'd0, (~val[31:0] + 32'd1)};
                        end
                    end
                    ita_pkg::OP_UDEC:
                    begin
                        radix = 64'd10;
                        mag   = {32'd0, val[31:0]};
                    end
                    ita_pkg::OP_HEXL:
                    begin
                        mag = {32'd0, val[31:0]};
                    end
                    ita_pkg::OP_HEXU:
                    begin
                        mag   = {32'd0, val[31:0]};
                        upper = 1'b1;
                    end
                    ita_pkg::OP_PTR:
                    begin
                        pending.push_back('{ch: 8'h30, last: 1'b0});
                        pending.push_back('{ch: 8'h78, last: 1'b0});
                    end
                    default:
                    begin
                        return;
                    end
                endcase
                nd = 0;
                do
                begin
                    digs[nd] = 4'(mag % radix);
                    mag      = mag / radix;
                    nd++;
                end
                while (mag != 64'd0 && nd < 16);
                for (int i = nd - 1; i >= 0; i--)
                begin
                    if (digs[i] < 4'd10)
                    begin
                        c = 8'h30 + {4'd0, digs[i]};
                    end
                    else
                    begin
                        c = (upper ? 8'h41 : 8'h61) + {4'd0, digs[i]} - 8'd10;
                    end
                    pending.push_back('{ch: c, last: (i == 0)});
                end
            end
        endfunction

        function void check_char(input logic [7:0] ch, input logic last);
            glyph_t want;
            begin
                chars_seen++;
                if (pending.size() == 0)
                begin
                    $error("unexpected word: character %h last %b", ch, last);
                    mismatches++;
                    return;
                end
                want = pending.pop_front();
                if (ch !== want.ch)
                begin
                    $error("character: expected %h, got %h", want.ch, ch);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, last);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        push  = 1'b0;
    logic        full;
    logic [2:0]  op    = '0;
    logic [63:0] value = '0;
    logic        empty;
    logic        pop   = 1'b0;
    logic [7:0]  character;
    logic        last;

    char_ledger ledger = new();
    bit         rx_holding = 1'b0;
    bit         tx_calm    = 1'b0;

    integer_to_ascii_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .character (character),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                return 0;
            end
            else if (r < 92)
            begin
                return $urandom_range(1, 3);
            end
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic logic [2:0] pick_format();
        int r;
        begin
            r = $urandom_range(0, 19);
            case (r % 5)
                0: pick_format = ita_pkg::OP_SDEC;
                1: pick_format = ita_pkg::OP_UDEC;
                2: pick_format = ita_pkg::OP_HEXL;
                3: pick_format = ita_pkg::OP_HEXU;
                default: pick_format = ita_pkg::OP_PTR;
            endcase
            if (r >= 18)
            begin
                pick_format = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
            end
        end
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] one_hot;
        begin
            one_hot = 64'd1 << $urandom_range(0, 63);
            case ($urandom_range(0, 6))
                0: pick_value = {32'd0, 32'($urandom_range(0, 20))};
                1: pick_value = {$urandom, 32'($urandom_range(0, 20))};
                2: pick_value = one_hot;
                3: pick_value = one_hot - 64'd1;
                4: pick_value = {$urandom, 32'h8000_0000 ^ 32'($urandom_range(0, 3))};
                5: pick_value = {32'd0, $urandom};
                default: pick_value = {$urandom, $urandom};
            endcase
        end
    endfunction

    task automatic send_word(input logic [2:0] fmt, input logic [63:0] val);
        @(negedge clk);
        push  <= 1'b1;
        op    <= fmt;
        value <= val;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        ledger.note_word(fmt, val);
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        push <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // receiver: random stalls, calm stretches and two long hold-offs
    initial
    begin
        int stall_left;
        int hold_left;
        int holds_done;
        int stall;
        bit calm;
        stall_left = 0;
        hold_left  = 0;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            calm = ((ledger.chars_seen / 256) % 3) == 1;
            if (hold_left == 0 && holds_done < 2 &&
                ledger.chars_seen >= 800 + 1200 * holds_done)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                rx_holding = 1'b1;
                pop <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rx_holding = 1'b0;
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                rx_holding = 1'b0;
                stall = calm ? 0 : gap_len();
                if (stall > 0)
                begin
                    pop <= 1'b0;
                    stall_left = stall - 1;
                end
                else
                begin
                    pop <= 1'b1;
                end
            end
            @(posedge clk);
            if (pop && !empty)
            begin
                ledger.check_char(character, last);
            end
        end
    end

    // watchdog: count cycles with no word pushed and no character popped
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("integer_to_ascii_formatter_tb: errors");
        $finish;
    end

    initial
    begin
        int g;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(ita_pkg::OP_SDEC, 64'd0);
        send_word(ita_pkg::OP_SDEC, 64'd1);
        send_word(ita_pkg::OP_SDEC, 64'h0000_0000_FFFF_FFFF);
        send_word(ita_pkg::OP_SDEC, 64'h0000_0000_7FFF_FFFF);
        send_word(ita_pkg::OP_SDEC, 64'h0000_0000_8000_0000);
        send_word(ita_pkg::OP_SDEC, 64'hFFFF_FFFF_FFFF_FFF6);
        send_word(ita_pkg::OP_SDEC, 64'hDEAD_BEEF_0000_0123);
        send_word(ita_pkg::OP_UDEC, 64'd0);
        send_word(ita_pkg::OP_UDEC, 64'h0000_0000_FFFF_FFFF);
        send_word(ita_pkg::OP_UDEC, 64'd1000000000);
        send_word(ita_pkg::OP_UDEC, 64'hFFFF_FFFF_0000_0000);
        send_word(ita_pkg::OP_HEXL, 64'd0);
        send_word(ita_pkg::OP_HEXL, 64'h0000_0000_FFFF_FFFF);
        send_word(ita_pkg::OP_HEXL, 64'h5555_AAAA_ABCD_EF01);
        send_word(ita_pkg::OP_HEXU, 64'd0);
        send_word(ita_pkg::OP_HEXU, 64'h0000_0000_FFFF_FFFF);
        send_word(ita_pkg::OP_HEXU, 64'hAAAA_5555_1234_ABCD);
        send_word(ita_pkg::OP_PTR, 64'd0);
        send_word(ita_pkg::OP_PTR, 64'd1);
        send_word(ita_pkg::OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(ita_pkg::OP_PTR, 64'h8000_0000_0000_0000);
        send_word(ita_pkg::OP_PTR, 64'h0123_4567_89AB_CDEF);
        send_word(OP_UNUSED_FIRST, 64'h0000_0000_0000_0042);
        send_word(OP_UNUSED_MID, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_UNUSED_LAST, 64'd0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            tx_calm = (i >= 120 && i < 180);
            g = (rx_holding || tx_calm) ? 0 : gap_len();
            if (g > 0)
            begin
                idle_sender(g);
            end
            send_word(pick_format(), pick_value());
        end
        @(negedge clk);
        push <= 1'b0;

        while (ledger.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (ledger.mismatches == 0)
        begin
            $display("integer_to_ascii_formatter_tb: clean");
        end
        else
        begin
            $display("integer_to_ascii_formatter_tb: errors");
        end
        $finish;
    end

endmodule

@@ integer_to_ascii_formatter.f @@
sv/ita_pkg.sv
sv/ita_front.sv
sv/ita_queue.sv
sv/ita_back.sv
sv/integer_to_ascii_formatter.sv
tb/integer_to_ascii_formatter_tb.sv
